@@ design/ise_pkg.sv @@
// Integer stack engine package: command, status and op codes, queue entry type.
// No dependencies; every other design file but ise_if uses this package.
`timescale 1ns / 1ps

package ise_pkg;

  // Command codes on the input word.
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_LIST = 3'd1;
  localparam logic [2:0] CMD_PEEK = 3'd2;
  localparam logic [2:0] CMD_POP  = 3'd3;
  localparam logic [2:0] CMD_SWAP = 3'd4;
  localparam logic [2:0] CMD_NOP  = 3'd5;
  localparam logic [2:0] CMD_ADD  = 3'd6;
  localparam logic [2:0] CMD_RSVD = 3'd7;

  // Status codes on the result word.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_NOINT = 3'd4;

  // Entry pointer width for the largest supported stack (64 entries).
  localparam int unsigned PTR_W = 6;

  // Work the back end carries out for one classified command.
  typedef enum logic [2:0] {
    OP_STATUS,
    OP_PUSH,
    OP_PEEK,
    OP_SWAP,
    OP_ADD,
    OP_LIST
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [2:0]       status;
    logic [31:0]      value;
    logic [PTR_W-1:0] addr;   // push slot, or index of the top entry
  } entry_t;

endpackage

@@ design/ise_if.sv @@
// Integer stack engine channel interfaces: command word in, result word out.
// Depends on nothing; valid/ready handshake, a word moves when both are high.
`timescale 1ns / 1ps

interface ise_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] push_value;
  logic               value_ok;

  modport source (output valid, output cmd, output push_value, output value_ok,
                  input ready);
  modport sink   (input valid, input cmd, input push_value, input value_ok,
                  output ready);
endinterface

interface ise_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, output data, output status, output last,
                  input ready);
  modport sink   (input valid, input data, input status, input last,
                  output ready);
endinterface

@@ design/integer_stack_engine_top.sv @@
// Integer stack engine: bounded LIFO of signed 32-bit integers driven by commands.
// A result word passes the queue, the back end's registered memory read and state, and
// the output register. The back end takes a command only while idle, so the queue holds
// the next ones; swap needs a second write step and list one step per entry, due to the
// back-end sequencer, its single write port and registered memory reads.
// Reset: asynchronous, active low; empties the stack and queue, memory contents undefined.
`timescale 1ns / 1ps

module integer_stack_engine_top #(
  parameter int unsigned STACK_DEPTH = 32   // 2 to 64 entries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ise_in_if.sink    in_i,
  ise_out_if.source out_o
);

  // Front to queue: classified commands; the front keeps its own entry count,
  // since every command's effect on the count is known at classification.
  logic            fq_valid, fq_ready;
  ise_pkg::entry_t fq_entry;

  // Queue to back: the back end pops one entry when its sequencer is idle.
  logic            qb_valid, qb_ready;
  ise_pkg::entry_t qb_entry;

  ise_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (fq_valid),
    .q_entry_o (fq_entry),
    .q_ready_i (fq_ready)
  );

  // Two entries let the front accept while the back lists or waits on output.
  ise_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_entry_i (fq_entry),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_entry_o  (qb_entry),
    .pop_ready_i  (qb_ready)
  );

  // Back end owns the stack memory and the output register.
  ise_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_entry_i (qb_entry),
    .q_ready_o (qb_ready),
    .out_o     (out_o)
  );

endmodule

@@ design/ise_front.sv @@
// Integer stack engine front end: accepts command words, tracks the entry count
// and classifies each command into a queue entry. Depends on ise_pkg, ise_if.
`timescale 1ns / 1ps

module ise_front #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ise_in_if.sink          in_i,
  output logic            q_valid_o,
  output ise_pkg::entry_t q_entry_o,
  input  logic            q_ready_i
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] top_idx;
  logic          accept;
  logic          keep;
  logic          full, empty, short_stack;

  assign in_i.ready  = q_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign full        = (count_q == CW'(STACK_DEPTH));
  assign empty       = (count_q == '0);
  assign short_stack = (count_q < CW'(2));
  assign top_idx     = count_q - CW'(1);

  always_comb begin
    keep               = 1'b1;
    count_d            = count_q;
    q_entry_o.op       = ise_pkg::OP_STATUS;
    q_entry_o.status   = ise_pkg::ST_OK;
    q_entry_o.value    = in_i.push_value;
    q_entry_o.addr     = ise_pkg::PTR_W'(top_idx);
    unique case (in_i.cmd) inside
      ise_pkg::CMD_PUSH: begin
        if (full) begin
          q_entry_o.status = ise_pkg::ST_FULL;
        end else if (!in_i.value_ok) begin
          q_entry_o.status = ise_pkg::ST_NOINT;
        end else begin
          q_entry_o.op   = ise_pkg::OP_PUSH;
          q_entry_o.addr = ise_pkg::PTR_W'(count_q);
          count_d        = count_q + CW'(1);
        end
      end
      ise_pkg::CMD_LIST: begin
        if (empty) begin
          keep = 1'b0;   // drop: an empty listing gives no word
        end else begin
          q_entry_o.op = ise_pkg::OP_LIST;
        end
      end
      ise_pkg::CMD_PEEK: begin
        if (empty) q_entry_o.status = ise_pkg::ST_EMPTY;
        else       q_entry_o.op     = ise_pkg::OP_PEEK;
      end
      ise_pkg::CMD_POP: begin
        if (empty) q_entry_o.status = ise_pkg::ST_EMPTY;
        else       count_d          = count_q - CW'(1);
      end
      ise_pkg::CMD_SWAP: begin
        if (short_stack) q_entry_o.status = ise_pkg::ST_SHORT;
        else             q_entry_o.op     = ise_pkg::OP_SWAP;
      end
      ise_pkg::CMD_ADD: begin
        if (short_stack) begin
          q_entry_o.status = ise_pkg::ST_SHORT;
        end else begin
          q_entry_o.op = ise_pkg::OP_ADD;
          count_d      = count_q - CW'(1);
        end
      end
      ise_pkg::CMD_NOP, ise_pkg::CMD_RSVD: begin
        q_entry_o.status = ise_pkg::ST_OK;
      end
      default: begin
        q_entry_o.status = ise_pkg::ST_OK;
      end
    endcase
  end

  assign q_valid_o = in_i.valid && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count moved without an accepted word");

  a_drop_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !q_valid_o) |-> (in_i.cmd == ise_pkg::CMD_LIST && empty))
    else $error("word dropped that was not an empty listing");

endmodule

@@ design/ise_queue.sv @@
// Integer stack engine decoupling queue: two-entry FIFO of classified commands.
// Depends on ise_pkg for the entry type.
`timescale 1ns / 1ps

module ise_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ise_pkg::entry_t push_entry_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ise_pkg::entry_t pop_entry_o,
  input  logic            pop_ready_i
);

  ise_pkg::entry_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;
  logic            do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

@@ design/ise_back.sv @@
// Integer stack engine back end: stack memory, execution sequencer and the
// result output register. Depends on ise_pkg and ise_if.
`timescale 1ns / 1ps

module ise_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  ise_pkg::entry_t q_entry_i,
  output logic            q_ready_o,
  ise_out_if.source       out_o
);

  localparam int unsigned IW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_SWAP2 = 2'd2;

  logic [1:0]         state_q, state_d;
  ise_pkg::op_e       op_q;
  logic [2:0]         status_q;
  logic [31:0]        value_q;
  logic [IW-1:0]      idx_q, idx_d;
  logic [31:0]        rda_q, rdb_q;
  logic [31:0]        mem_q [STACK_DEPTH];

  logic               rd_en;
  logic [IW-1:0]      raddr_a, raddr_b, entry_idx;
  logic               mem_we;
  logic [IW-1:0]      waddr;
  logic [31:0]        wdata;

  logic               can_emit, emit;
  logic [31:0]        e_data;
  logic [2:0]         e_status;
  logic               e_last;

  logic               out_valid_q;
  logic signed [31:0] out_data_q;
  logic [2:0]         out_status_q;
  logic               out_last_q;

  assign can_emit  = !out_valid_q || out_o.ready;
  assign entry_idx = IW'(q_entry_i.addr);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    q_ready_o = 1'b0;
    rd_en     = 1'b0;
    raddr_a   = idx_q;
    raddr_b   = idx_q - IW'(1);
    mem_we    = 1'b0;
    waddr     = idx_q;
    wdata     = value_q;
    emit      = 1'b0;
    e_data    = '0;
    e_status  = status_q;
    e_last    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          rd_en   = 1'b1;
          raddr_a = entry_idx;
          raddr_b = entry_idx - IW'(1);
          idx_d   = entry_idx;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (can_emit) begin
          emit = 1'b1;
          case (op_q)
            ise_pkg::OP_LIST: begin
              e_data = rda_q;
              e_last = (idx_q == '0);
              if (idx_q == '0) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q - IW'(1);
                rd_en   = 1'b1;
                raddr_a = idx_q - IW'(1);
                state_d = S_RUN;
              end
            end
            ise_pkg::OP_PUSH: begin
              mem_we  = 1'b1;
              state_d = S_IDLE;
            end
            ise_pkg::OP_PEEK: begin
              e_data  = rda_q;
              state_d = S_IDLE;
            end
            ise_pkg::OP_ADD: begin
              mem_we  = 1'b1;
              waddr   = idx_q - IW'(1);
              wdata   = rda_q + rdb_q;
              state_d = S_IDLE;
            end
            ise_pkg::OP_SWAP: begin
              mem_we  = 1'b1;
              wdata   = rdb_q;
              state_d = S_SWAP2;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SWAP2: begin
        mem_we  = 1'b1;
        waddr   = idx_q - IW'(1);
        wdata   = rda_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Stack memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (rd_en) begin
      rda_q <= mem_q[raddr_a];
      rdb_q <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      op_q     <= q_entry_i.op;
      status_q <= q_entry_i.status;
      value_q  <= q_entry_i.value;
    end
    if (emit) begin
      out_data_q   <= e_data;
      out_status_q <= e_status;
      out_last_q   <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;
  assign out_o.status = out_status_q;
  assign out_o.last   = out_last_q;

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP2 |-> $past(state_q) == S_RUN && $past(emit))
    else $error("second swap write without its first half");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we && !emit)
    else $error("memory write or result while idle");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit)
    else $error("result overwrote an untaken word");

endmodule
